[rtl/stip_pkg.sv]
// Shared types and constants for the string-to-integer parser.
// No dependencies; imported by every module of the block.
package stip_pkg;

  // Register layout of the configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_RADIX    = 1'b0;
  localparam logic REG_UNSIGNED = 1'b1;
  localparam logic [5:0] RADIX_RESET = 6'd10;

  // Bases and character codes
  localparam logic [5:0] BASE_MAX = 6'd36;
  localparam logic [5:0] BASE_MIN = 6'd2;
  localparam logic [5:0] BASE_HEX = 6'd16;
  localparam logic [5:0] BASE_DEC = 6'd10;
  localparam logic [5:0] BASE_OCT = 6'd8;
  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_BAD = 6'd1;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5A;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LZ    = 8'h7A;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LX    = 8'h78;
  localparam logic [7:0] UPPER_OFS = CH_UA - 8'd10;
  localparam logic [7:0] LOWER_OFS = CH_LA - 8'd10;

  // Output field widths
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned END_W   = 16;

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_PREFIX,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  // One classified byte as it travels from front to back
  typedef struct packed {
    logic [5:0] digit;
    logic       alnum;
    logic       space;
    logic       sign;
    logic       minus;
    logic       is_x;
    logic       is_zero;
    logic       nz_dec;
    logic       last;
  } item_t;

  // Status that goes with a finished number
  typedef struct packed {
    logic found;
    logic negative;
    logic overflowed;
    logic unsigned_mode;
  } res_flags_t;

endpackage

[rtl/stip_front.sv]
// Front end: classifies each incoming byte into a queue entry.
// Depends on stip_pkg.
module stip_front import stip_pkg::*; (
  input  logic [7:0] ch,
  input  logic       last,
  output item_t      item
);

  logic [7:0] ofs;

  always_comb begin
    item = '0;
    ofs = 8'd0;
    item.last = last;
    item.space = ((ch >= CH_TAB) && (ch <= CH_CR)) || (ch == CH_SPACE);
    item.sign = (ch == CH_PLUS) || (ch == CH_MINUS);
    item.minus = (ch == CH_MINUS);
    item.is_x = (ch == CH_UX) || (ch == CH_LX);
    item.is_zero = (ch == CH_0);
    item.nz_dec = (ch >= CH_1) && (ch <= CH_9);
    if ((ch >= CH_0) && (ch <= CH_9)) begin
      ofs = CH_0;
      item.alnum = 1'b1;
    end else if ((ch >= CH_UA) && (ch <= CH_UZ)) begin
      ofs = UPPER_OFS;
      item.alnum = 1'b1;
    end else if ((ch >= CH_LA) && (ch <= CH_LZ)) begin
      ofs = LOWER_OFS;
      item.alnum = 1'b1;
    end
    item.digit = item.alnum ? 6'(ch - ofs) : 6'd0;
  end

endmodule

[rtl/stip_fifo.sv]
// Small register queue with simultaneous push and pop.
// Depends on stip_pkg for the house import only.
module stip_fifo import stip_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full = (count == CNT_W'(DEPTH));
  assign empty = (count == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/stip_back.sv]
// Back end: parse state machine with the multiply-add and range check.
// Depends on stip_pkg; takes classified bytes and emits finished numbers.
module stip_back import stip_pkg::*; #(
  parameter int unsigned WORD_BITS   = 64,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   item_valid,
  input  item_t                  item,
  output logic                   item_ready,
  input  logic [5:0]             radix,
  input  logic                   unsigned_mode,
  input  logic                   res_ready,
  output logic                   res_valid,
  output logic [WORD_BITS-1:0]   res_acc,
  output res_flags_t             res_flags,
  output logic [OFFSET_BITS-1:0] res_end
);

  localparam int unsigned PROD_W = WORD_BITS + 7;
  localparam logic [WORD_BITS-1:0] SIGN_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};
  localparam logic [WORD_BITS-1:0] SIGN_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};
  localparam logic [WORD_BITS-1:0] WORD_ONES = '1;
  localparam logic [OFFSET_BITS-1:0] COUNT_MAX = '1;

  phase_t                 phase, phase_next;
  logic [WORD_BITS-1:0]   acc, acc_next;
  logic                   negative, negative_next;
  logic                   overflowed, overflowed_next;
  logic [5:0]             active_base, active_base_next;
  logic [OFFSET_BITS-1:0] byte_count, byte_count_next;
  logic [OFFSET_BITS-1:0] end_mark, end_mark_next;

  logic                   take;
  logic                   do_take;
  logic                   digit_ok;
  logic [WORD_BITS-1:0]   limit;
  logic [PROD_W-1:0]      prod;

  assign item_ready = !item.last || res_ready;
  assign take = item_valid && item_ready;
  assign res_valid = take && item.last;

  // One multiply-add per byte; compare against the active limit
  assign prod = PROD_W'(acc) * PROD_W'(active_base_next) + PROD_W'(item.digit);

  always_comb begin
    if (unsigned_mode) begin
      limit = WORD_ONES;
    end else if (negative_next) begin
      limit = SIGN_MIN;
    end else begin
      limit = SIGN_MAX;
    end
  end

  always_comb begin
    phase_next = phase;
    acc_next = acc;
    negative_next = negative;
    overflowed_next = overflowed;
    active_base_next = active_base;
    end_mark_next = end_mark;
    do_take = 1'b0;
    byte_count_next = (byte_count != COUNT_MAX) ? byte_count + 1'b1 : byte_count;

    unique case (phase)
      PH_SPACE, PH_SIGNED: begin
        if ((phase == PH_SPACE) && item.space) begin
          phase_next = PH_SPACE;
        end else if ((phase == PH_SPACE) && item.sign) begin
          negative_next = item.minus;
          phase_next = PH_SIGNED;
        end else if ((radix == BASE_BAD) || (radix > BASE_MAX)) begin
          phase_next = PH_DONE;
        end else if (radix == BASE_AUTO) begin
          if (item.is_zero) begin
            active_base_next = BASE_AUTO;
            end_mark_next = byte_count_next;
            phase_next = PH_ZERO;
          end else if (item.nz_dec) begin
            active_base_next = BASE_DEC;
            do_take = 1'b1;
          end else begin
            phase_next = PH_DONE;
          end
        end else begin
          active_base_next = radix;
          if (item.is_zero && (radix == BASE_HEX)) begin
            end_mark_next = byte_count_next;
            phase_next = PH_ZERO;
          end else begin
            do_take = 1'b1;
          end
        end
      end
      PH_ZERO: begin
        if (item.is_x) begin
          active_base_next = BASE_HEX;
          phase_next = PH_PREFIX;
        end else begin
          if (active_base == BASE_AUTO) begin
            active_base_next = BASE_OCT;
          end
          do_take = 1'b1;
        end
      end
      PH_PREFIX, PH_DIGITS: begin
        do_take = 1'b1;
      end
      PH_DONE: begin
        phase_next = PH_DONE;
      end
      default: begin
        phase_next = PH_DONE;
      end
    endcase

    digit_ok = (active_base_next >= BASE_MIN) && (active_base_next <= BASE_MAX) &&
               item.alnum && (item.digit < active_base_next);

    if (do_take) begin
      if (!digit_ok) begin
        phase_next = PH_DONE;
      end else begin
        if (!overflowed) begin
          if (prod <= PROD_W'(limit)) begin
            acc_next = prod[WORD_BITS-1:0];
          end else begin
            overflowed_next = 1'b1;
          end
        end
        end_mark_next = byte_count_next;
        phase_next = PH_DIGITS;
      end
    end
  end

  assign res_acc = acc_next;
  assign res_end = end_mark_next;
  assign res_flags = '{found: (end_mark_next != '0), negative: negative_next,
                       overflowed: overflowed_next, unsigned_mode: unsigned_mode};

  always_ff @(posedge clk) begin
    if (rst || res_valid) begin
      phase <= PH_SPACE;
      acc <= '0;
      negative <= 1'b0;
      overflowed <= 1'b0;
      active_base <= '0;
      byte_count <= '0;
      end_mark <= '0;
    end else if (take) begin
      phase <= phase_next;
      acc <= acc_next;
      negative <= negative_next;
      overflowed <= overflowed_next;
      active_base <= active_base_next;
      byte_count <= byte_count_next;
      end_mark <= end_mark_next;
    end
  end

endmodule

[rtl/string_to_integer_parser_core.sv]
// Top level of the string-to-integer parser: config registers, queues, formatting.
// Depends on stip_pkg, stip_front, stip_fifo and stip_back.
//
//   channel   direction  handshake                 payload
//   -------   ---------  ------------------------  ----------------------------
//   input     in         push / full               ch[7:0], last
//   result    out        pop / empty               value[63:0], overflow,
//                                                  end_offset[15:0]
//   config    in/out     psel, penable, pwrite,    paddr[2:0], pwdata, prdata
//                        pready (always high)
//
// One byte per cycle sustained while the result queue has room: the back end's
// multiply-add and limit compare are combinational. A byte reaches the back end
// through the byte queue's registers; its result is pushed into the result queue
// as the last byte leaves the byte queue. Reset clears queues and parse state and
// sets radix to 10, unsigned mode off. A stalled result queue holds the back
// end only on a last byte; other bytes keep flowing until the byte queue fills.
module string_to_integer_parser_core import stip_pkg::*; #(
  parameter int unsigned WORD_BITS    = 64,
  parameter int unsigned OFFSET_BITS  = 16,
  parameter int unsigned QUEUE_DEPTH  = 4,
  parameter int unsigned RESULT_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  // byte input
  input  logic                  push,
  output logic                  full,
  input  logic [7:0]            ch,
  input  logic                  last,
  // result output
  input  logic                  pop,
  output logic                  empty,
  output logic [VALUE_W-1:0]    value,
  output logic                  overflow,
  output logic [END_W-1:0]      end_offset,
  // configuration
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int unsigned ITEM_W = $bits(item_t);
  localparam int unsigned FLAG_W = $bits(res_flags_t);
  localparam int unsigned RES_W  = WORD_BITS + FLAG_W + OFFSET_BITS;
  localparam logic [WORD_BITS-1:0] SIGN_MIN = {1'b1, {(WORD_BITS - 1){1'b0}}};
  localparam logic [WORD_BITS-1:0] SIGN_MAX = {1'b0, {(WORD_BITS - 1){1'b1}}};

  // Configuration registers
  logic [5:0] radix;
  logic       unsigned_mode;
  logic       cfg_write;

  // Front to back
  item_t               front_item;
  logic [ITEM_W-1:0]   q_data;
  logic                q_empty;
  logic                q_pop;

  // Back to result queue
  logic                   res_valid;
  logic                   res_full;
  logic [WORD_BITS-1:0]   res_acc;
  res_flags_t             res_flags;
  logic [OFFSET_BITS-1:0] res_end;
  logic [RES_W-1:0]       out_data;

  // Head of result queue
  logic [WORD_BITS-1:0]   head_acc;
  res_flags_t             head_flags;
  logic [OFFSET_BITS-1:0] head_end;
  logic [WORD_BITS-1:0]   head_value;
  logic [31:0]            end_wide;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
      unsigned_mode <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_RADIX:    radix <= pwdata[5:0];
        REG_UNSIGNED: unsigned_mode <= pwdata[0];
        default:      radix <= radix;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_RADIX:    prdata = {26'd0, radix};
      REG_UNSIGNED: prdata = {31'd0, unsigned_mode};
      default:      prdata = 32'd0;
    endcase
  end

  // Classify the byte on the way into the queue
  stip_front u_front (
    .ch   (ch),
    .last (last),
    .item (front_item)
  );

  stip_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_byte_q (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (front_item),
    .full      (full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  stip_back #(
    .WORD_BITS   (WORD_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .item_valid    (!q_empty),
    .item          (item_t'(q_data)),
    .item_ready    (q_pop),
    .radix         (radix),
    .unsigned_mode (unsigned_mode),
    .res_ready     (!res_full),
    .res_valid     (res_valid),
    .res_acc       (res_acc),
    .res_flags     (res_flags),
    .res_end       (res_end)
  );

  stip_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RESULT_DEPTH)
  ) u_result_q (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data ({res_acc, res_flags, res_end}),
    .full      (res_full),
    .pop       (pop),
    .pop_data  (out_data),
    .empty     (empty)
  );

  assign {head_acc, head_flags, head_end} = out_data;

  // Saturate on overflow, negate a minus number, zero when nothing was found
  always_comb begin
    priority if (!head_flags.found) begin
      head_value = '0;
    end else if (head_flags.overflowed && head_flags.unsigned_mode) begin
      head_value = '1;
    end else if (head_flags.overflowed) begin
      head_value = head_flags.negative ? SIGN_MIN : SIGN_MAX;
    end else if (head_flags.negative) begin
      head_value = '0 - head_acc;
    end else begin
      head_value = head_acc;
    end
  end

  assign value = VALUE_W'(head_value);
  assign overflow = head_flags.found && head_flags.overflowed;
  assign end_wide = head_flags.found ? 32'(head_end) : 32'd0;
  assign end_offset = end_wide[END_W-1:0];

endmodule

[rtl/stip_checker.sv]
// Port-level checks for the string-to-integer parser, bound to its top level.
// Depends on stip_pkg and string_to_integer_parser_core.
module stip_checker import stip_pkg::*; #(
  parameter int unsigned OFFSET_BITS = 16
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  full,
  input logic                  pop,
  input logic                  empty,
  input logic [VALUE_W-1:0]    value,
  input logic                  overflow,
  input logic [END_W-1:0]      end_offset,
  input logic                  pready
);

  // Queues come out of reset with nothing held and room for bytes
  a_reset_state: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not cleared by reset");

  // A waiting result holds until taken
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> ($stable(value) && $stable(overflow) && $stable(end_offset)))
    else $error("result changed while waiting");

  // No number found means a zero value and no overflow
  a_no_number: assert property (@(posedge clk) disable iff (rst)
    ((OFFSET_BITS <= END_W) && !empty && (end_offset == '0)) |-> ((value == '0) && !overflow))
    else $error("empty result carries data");

  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready dropped");

endmodule

bind string_to_integer_parser_core stip_checker #(
  .OFFSET_BITS (OFFSET_BITS)
) u_stip_checker (
  .clk        (clk),
  .rst        (rst),
  .full       (full),
  .pop        (pop),
  .empty      (empty),
  .value      (value),
  .overflow   (overflow),
  .end_offset (end_offset),
  .pready     (pready)
);
